/* rtl/round_robin_time_slice_scheduler_defines.svh */
// Assertion macros for the round-robin time-slice scheduler.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define RRTS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
// A condition that implies another in the same cycle.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// A condition that implies another in the next cycle.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRTS_ASSERT(lbl, cond, msg)
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg)
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/rrts_pkg.sv */
// Types, constants and saturating helpers shared by the scheduler modules.
package rrts_pkg;

  localparam int unsigned TIME_W     = 16;
  localparam int unsigned CLK_W      = 20;
  localparam int unsigned TOT_W      = 23;
  localparam int unsigned PIDX_W     = 3;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W  = 2;
  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic [CLK_W-1:0] CLK_MAX = {CLK_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Operation codes carried on the input tuser bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // One process record as held in the process table.
  typedef struct packed {
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] arrival;
    logic [CLK_W-1:0]  wait_acc;
    logic [CLK_W-1:0]  last_end;
  } proc_rec_t;

  // Write controls from the sequencer to the process table.
  typedef struct packed {
    logic we;
    logic set_started;
    logic clr_started;
  } tbl_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Saturating add on the 20-bit time scale.
  function automatic logic [CLK_W-1:0] sat_add20(input logic [CLK_W-1:0] a,
                                                 input logic [CLK_W-1:0] b);
    logic [CLK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CLK_W] ? CLK_MAX : s[CLK_W-1:0];
  endfunction

  // Saturating add of a 20-bit time onto a 23-bit total.
  function automatic logic [TOT_W-1:0] sat_add23(input logic [TOT_W-1:0] a,
                                                 input logic [CLK_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {{(TOT_W-CLK_W+1){1'b0}}, b};
    return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
  endfunction

endpackage

/* rtl/rrts_proc_table.sv */
// Process table: record memory with registered read and per-entry started flags.
module rrts_proc_table import rrts_pkg::*; #(
  parameter int unsigned MAX_PROCS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbl_ctl_t                       ctl,
  input  logic [$clog2(MAX_PROCS)-1:0]   wr_idx,
  input  proc_rec_t                      wr_rec,
  input  logic [$clog2(MAX_PROCS)-1:0]   rd_idx,
  output proc_rec_t                      rd_rec,
  input  logic [$clog2(MAX_PROCS)-1:0]   st_idx,
  output logic                           st_flag
);

  proc_rec_t mem [MAX_PROCS];
  proc_rec_t rd_rec_r;
  logic      started_r [MAX_PROCS];

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_idx] <= wr_rec;
    end
    rd_rec_r <= mem[rd_idx];
  end

  // Started flags are cleared by reset and by a load of the entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(MAX_PROCS); i++) begin
        started_r[i] <= 1'b0;
      end
    end else if (ctl.we && ctl.clr_started) begin
      started_r[wr_idx] <= 1'b0;
    end else if (ctl.we && ctl.set_started) begin
      started_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_rec  = rd_rec_r;
  assign st_flag = started_r[st_idx];

endmodule

/* rtl/round_robin_time_slice_scheduler.sv */
// Round-robin time-slice scheduler: a load item gives no result. A step item is accepted,
// then the scan reads the table entries one after another and checks each read's data
// (stopping at the first ready process), then the slice is worked out, and then the
// record is written back and the result registered; a result still held on the output
// adds its wait. Items go one at a time.
// Reset clears the clock, counters, totals and started flags and sets quantum to 4.
`include "round_robin_time_slice_scheduler_defines.svh"
module round_robin_time_slice_scheduler import rrts_pkg::*; #(
  parameter int unsigned MAX_PROCS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration: quantum.
  input  logic                    cfg_wr_en,
  input  logic [TIME_W-1:0]       cfg_wr_data,
  // Input channel.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // burst[15:0], arrival[31:16]
  input  logic                    in_tuser,   // operation
  // Result channel.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // proc_index[2:0], slice_end[22:3], finished[23], proc_wait[43:24],
  // proc_turnaround[63:44], total_wait[86:64], total_turnaround[109:87], zero pad
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tuser   // all_done
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCS - 1);

  // Control registers.
  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   quantum_r, quantum_nxt;
  logic [CLK_W-1:0]    clk_r, clk_nxt;
  logic [IDX_W-1:0]    scan_pos_r, scan_pos_nxt;
  logic [CNT_W-1:0]    loaded_cnt_r, loaded_cnt_nxt;
  logic [CNT_W-1:0]    fin_cnt_r, fin_cnt_nxt;
  logic [TOT_W-1:0]    wsum_r, wsum_nxt;
  logic [TOT_W-1:0]    tsum_r, tsum_nxt;
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic                cand_v_r, cand_v_nxt;
  logic                cand_elig_r, cand_elig_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // Payload registers.
  logic [IDX_W-1:0]       rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   chk_last_r, chk_last_nxt;
  logic [IDX_W-1:0]       cand_idx_r, cand_idx_nxt;
  proc_rec_t              cand_r, cand_nxt;
  logic [CLK_W-1:0]       wait_new_r, wait_new_nxt;
  logic [TIME_W-1:0]      rem_new_r, rem_new_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r, out_tuser_nxt;

  // Process table connections.
  tbl_ctl_t          tbl_ctl;
  logic [IDX_W-1:0]  tbl_wr_idx;
  proc_rec_t         tbl_wr_rec;
  proc_rec_t         tbl_rd_rec;
  logic              started_sel;

  // Datapath intermediates.
  logic               in_acc;
  logic               slot_free;
  logic               issue_act;
  logic               pending;
  logic               elig;
  logic               take;
  logic               scan_end;
  logic [IDX_W-1:0]   scan_start;
  logic [TIME_W-1:0]  burst_in;
  logic [TIME_W-1:0]  arrival_in;
  logic [CLK_W-1:0]   clk_eff;
  logic [CLK_W-1:0]   gap;
  logic [TIME_W-1:0]  q_eff;
  logic [TIME_W-1:0]  run;
  logic               fin;
  logic [CLK_W-1:0]   pw;
  logic [CLK_W-1:0]   pt;

  rrts_proc_table #(
    .MAX_PROCS (MAX_PROCS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_idx  (tbl_wr_idx),
    .wr_rec  (tbl_wr_rec),
    .rd_idx  (rd_addr_r),
    .rd_rec  (tbl_rd_rec),
    .st_idx  (cand_idx_r),
    .st_flag (started_sel)
  );

  assign burst_in   = in_tdata[TIME_W-1:0];
  assign arrival_in = in_tdata[2*TIME_W-1:TIME_W];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_tvalid_r || out_tready;

  // The scan starts at the saved position, or at entry 0 if that lies past the table.
  assign scan_start = (CNT_W'(scan_pos_r) < loaded_cnt_r) ? scan_pos_r : '0;

  // Scan evaluation of the entry whose read data has just arrived. The candidate is
  // the first ready process in scan order, or failing that the first with the
  // earliest arrival; a ready process always arrives before any waiting one.
  assign issue_act = (issue_cnt_r < loaded_cnt_r);
  assign pending   = (tbl_rd_rec.remaining != '0);
  assign elig      = pending && ({{(CLK_W-TIME_W){1'b0}}, tbl_rd_rec.arrival} <= clk_r);
  assign take      = chk_v_r && pending && !cand_elig_r &&
                     (!cand_v_r || (tbl_rd_rec.arrival < cand_r.arrival));
  assign scan_end  = chk_v_r && ((take && elig) || chk_last_r);

  // Slice arithmetic on the chosen record; an idle clock jumps to its arrival.
  assign clk_eff = cand_elig_r ? clk_r : {{(CLK_W-TIME_W){1'b0}}, cand_r.arrival};
  assign gap     = clk_eff - (started_sel ? cand_r.last_end
                                          : {{(CLK_W-TIME_W){1'b0}}, cand_r.arrival});
  assign q_eff   = (quantum_r == '0) ? TIME_W'(1) : quantum_r;
  assign run     = (cand_r.remaining < q_eff) ? cand_r.remaining : q_eff;

  // Completion figures, taken from the registered slice results.
  assign fin = (rem_new_r == '0);
  assign pw  = fin ? wait_new_r : '0;
  assign pt  = fin ? (clk_r - {{(CLK_W-TIME_W){1'b0}}, cand_r.arrival}) : '0;

  // Sequencer and table write control.
  always_comb begin
    state_nxt      = state_r;
    quantum_nxt    = cfg_wr_en ? cfg_wr_data : quantum_r;
    clk_nxt        = clk_r;
    scan_pos_nxt   = scan_pos_r;
    loaded_cnt_nxt = loaded_cnt_r;
    fin_cnt_nxt    = fin_cnt_r;
    wsum_nxt       = wsum_r;
    tsum_nxt       = tsum_r;
    issue_cnt_nxt  = issue_cnt_r;
    chk_v_nxt      = 1'b0;
    cand_v_nxt     = cand_v_r;
    cand_elig_nxt  = cand_elig_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_addr_nxt    = rd_addr_r;
    chk_idx_nxt    = rd_addr_r;
    chk_last_nxt   = (issue_cnt_r == (loaded_cnt_r - CNT_ONE));
    cand_idx_nxt   = cand_idx_r;
    cand_nxt       = cand_r;
    wait_new_nxt   = wait_new_r;
    rem_new_nxt    = rem_new_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    tbl_ctl        = '0;
    tbl_wr_idx     = cand_idx_r;
    tbl_wr_rec     = '{remaining: rem_new_r, arrival: cand_r.arrival,
                       wait_acc: wait_new_r, last_end: clk_r};

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_LOAD)) begin
          // A load appends a record; zero bursts and a full table are ignored.
          if ((burst_in != '0) && (loaded_cnt_r < CNT_FULL)) begin
            tbl_ctl.we          = 1'b1;
            tbl_ctl.clr_started = 1'b1;
            tbl_wr_idx          = loaded_cnt_r[IDX_W-1:0];
            tbl_wr_rec          = '{remaining: burst_in, arrival: arrival_in,
                                    wait_acc: '0, last_end: '0};
            loaded_cnt_nxt      = loaded_cnt_r + CNT_ONE;
          end
        end else if (in_acc) begin
          if (fin_cnt_r >= loaded_cnt_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt     = ST_SCAN;
            rd_addr_nxt   = scan_start;
            issue_cnt_nxt = '0;
            cand_v_nxt    = 1'b0;
            cand_elig_nxt = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle, wrapping over the loaded entries.
        if (issue_act) begin
          chk_v_nxt     = 1'b1;
          issue_cnt_nxt = issue_cnt_r + CNT_ONE;
          rd_addr_nxt   = (CNT_W'(rd_addr_r) == (loaded_cnt_r - CNT_ONE)) ? '0
                                                                          : rd_addr_r + IDX_ONE;
        end
        if (take) begin
          cand_v_nxt    = 1'b1;
          cand_elig_nxt = elig;
          cand_idx_nxt  = chk_idx_r;
          cand_nxt      = tbl_rd_rec;
        end
        if (scan_end) begin
          chk_v_nxt     = 1'b0;
          issue_cnt_nxt = loaded_cnt_r;
          state_nxt     = (cand_v_r || take) ? ST_EXEC : ST_DONE;
        end
      end

      ST_EXEC: begin
        // Waiting time update, run length and new clock.
        if (started_sel) begin
          wait_new_nxt = sat_add20(cand_r.wait_acc, gap);
        end else begin
          wait_new_nxt = gap;
        end
        clk_nxt     = sat_add20(clk_eff, {{(CLK_W-TIME_W){1'b0}}, run});
        rem_new_nxt = cand_r.remaining - run;
        state_nxt   = ST_COMMIT;
      end

      ST_COMMIT: begin
        // Write the record back and register the result once the slot is free.
        if (slot_free) begin
          tbl_ctl.we          = 1'b1;
          tbl_ctl.set_started = 1'b1;
          scan_pos_nxt        = (cand_idx_r == IDX_LAST) ? '0 : cand_idx_r + IDX_ONE;
          if (fin) begin
            fin_cnt_nxt = fin_cnt_r + CNT_ONE;
            wsum_nxt    = sat_add23(wsum_r, pw);
            tsum_nxt    = sat_add23(tsum_r, pt);
          end
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = 1'b0;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, tsum_nxt, wsum_nxt, pt, pw, fin, clk_r,
                            PIDX_W'(cand_idx_r)};
          state_nxt      = ST_IDLE;
        end
      end

      ST_DONE: begin
        // Nothing left to run: only the totals are reported.
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, tsum_r, wsum_r, {CLK_W{1'b0}},
                            {CLK_W{1'b0}}, 1'b0, {CLK_W{1'b0}}, {PIDX_W{1'b0}}};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      quantum_r    <= TIME_W'(4);
      clk_r        <= '0;
      scan_pos_r   <= '0;
      loaded_cnt_r <= '0;
      fin_cnt_r    <= '0;
      wsum_r       <= '0;
      tsum_r       <= '0;
      issue_cnt_r  <= '0;
      chk_v_r      <= 1'b0;
      cand_v_r     <= 1'b0;
      cand_elig_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      quantum_r    <= quantum_nxt;
      clk_r        <= clk_nxt;
      scan_pos_r   <= scan_pos_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      fin_cnt_r    <= fin_cnt_nxt;
      wsum_r       <= wsum_nxt;
      tsum_r       <= tsum_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      chk_v_r      <= chk_v_nxt;
      cand_v_r     <= cand_v_nxt;
      cand_elig_r  <= cand_elig_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    chk_last_r  <= chk_last_nxt;
    cand_idx_r  <= cand_idx_nxt;
    cand_r      <= cand_nxt;
    wait_new_r  <= wait_new_nxt;
    rem_new_r   <= rem_new_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks on the sequencer.
  `RRTS_ASSERT(a_fin_le_loaded, fin_cnt_r <= loaded_cnt_r, "more finished than loaded")
  `RRTS_ASSERT_IMP(a_scan_has_work, state_r == ST_SCAN, fin_cnt_r < loaded_cnt_r, "scan without work")
  `RRTS_ASSERT_IMP(a_exec_has_cand, state_r == ST_EXEC, cand_v_r, "slice without a candidate")
  `RRTS_ASSERT_NEXT(a_commit_emits, (state_r == ST_COMMIT) && slot_free, out_tvalid_r && !out_tuser_r, "slice result not registered")

endmodule
